[rtl/wgr_pkg.sv]
// ============================================================================
// Window glitch remover package
// Shared widths, codes, the queued operation record and the absolute
// difference helper used by the front and back sections.
// ============================================================================
`default_nettype none

package wgr_pkg;

   // Default depth of one analysis window; the sample store holds two.
   localparam int DEFAULT_MAX_WINDOW = 1024;

   // Field and datapath widths.
   localparam int SAMPLE_W = 32;
   localparam int LEN_W    = 11;
   localparam int ALPHA_W  = 16;
   localparam int MODE_W   = 2;
   localparam int COUNT_W  = 20;
   localparam int SUM_W    = 44;
   localparam int THR_W    = 43;
   localparam int FRAC_W   = 12;
   localparam int NUM_W    = SUM_W + FRAC_W;
   localparam int DEN_W    = LEN_W + ALPHA_W;
   localparam int IDX_W    = 2;
   localparam int CSR_W    = 16;
   localparam int RSP_W    = 56;

   // Depth of the operation queue between the two sections.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes on the configuration channel.
   localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
   localparam logic [IDX_W-1:0] REG_ALPHA      = 2'd1;
   localparam logic [IDX_W-1:0] REG_MODE       = 2'd2;

   // Register reset values.
   localparam logic [LEN_W-1:0]   WINDOW_LEN_RESET = 11'd500;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET      = 16'd410;
   localparam logic [MODE_W-1:0]  MODE_RESET       = 2'd1;

   // Correction modes.
   localparam logic [MODE_W-1:0] MODE_FLAG   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INTERP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd2;

   // Input item kinds.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   // Saturation limit of the glitch counter.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // One classified item, passed from the front to the back section.
   typedef struct packed {
      logic                wr;
      logic [SAMPLE_W-1:0] sample;
      logic                emit;
      logic                corrected;
      logic                has_next;
      logic                is_last;
      logic                win_done;
      logic [SUM_W-1:0]    diff_sum;
      logic [SAMPLE_W-1:0] head;
      logic [LEN_W-1:0]    win_len;
   } op_type;

   // Fill status of the operation queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back section sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RD_CUR,
      ST_RD_PREV,
      ST_RD_NEXT,
      ST_EVAL,
      ST_DIV_START,
      ST_DIV_WAIT
   } back_state_type;

   // Magnitude of the difference of two signed samples; it always fits 32 bits.
   function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
      logic [SAMPLE_W:0] d;
      logic [SAMPLE_W:0] n;
      d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      n = -d;
      return d[SAMPLE_W] ? n[SAMPLE_W-1:0] : d[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/wgr_front.sv]
// ============================================================================
// Window glitch remover front section
// Accepts input transfers, keeps the record and window bookkeeping, sums the
// backward differences and queues one classified operation per sample or non-empty drain.
// ============================================================================
`default_nettype none

module wgr_front
   import wgr_pkg::*;
#(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [SAMPLE_W-1:0] req_tdata,
   input  wire logic                req_tuser,
   input  wire logic [LEN_W-1:0]    cfg_window_len,
   input  wire queue_status_type    q_status,
   output logic                     push,
   output op_type                   push_op
);

   localparam logic [LEN_W-1:0] WIN_MAX =
      (MAX_WINDOW >= 2047) ? {LEN_W{1'b1}} : LEN_W'(MAX_WINDOW);

   logic                started_ff, started_in;
   logic [LEN_W-1:0]    win_len_ff, win_len_in;
   logic [LEN_W-1:0]    in_phase_ff, in_phase_in;
   logic [LEN_W:0]      pending_ff, pending_in;
   logic [SUM_W-1:0]    diff_sum_ff, diff_sum_in;
   logic [SAMPLE_W-1:0] last_ff, last_in;
   logic [SAMPLE_W-1:0] head_ff, head_in;

   logic                accept;
   logic [LEN_W-1:0]    len_clamped;
   logic                phase_zero;
   logic [SUM_W-1:0]    diff_new;
   logic [SAMPLE_W-1:0] head_new;
   logic [LEN_W-1:0]    phase_new;
   logic [LEN_W:0]      pend_new;
   logic                emit_now;

   // The queue decides when the next transfer may be taken.
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid & req_tready;

   // Window length is clamped to the supported range at the start of a record.
   always_comb begin
      if (cfg_window_len < LEN_W'(2)) begin
         len_clamped = LEN_W'(2);
      end else if (cfg_window_len > WIN_MAX) begin
         len_clamped = WIN_MAX;
      end else begin
         len_clamped = cfg_window_len;
      end
   end

   // Sample bookkeeping for a sample that continues a record.
   always_comb begin
      phase_zero = (in_phase_ff == '0);
      diff_new   = diff_sum_ff +
                   (phase_zero ? '0 : SUM_W'(abs_diff(req_tdata, last_ff)));
      head_new   = phase_zero ? req_tdata : head_ff;
      phase_new  = in_phase_ff + LEN_W'(1);
      pend_new   = pending_ff + (LEN_W+1)'(1);
      emit_now   = (pend_new > {1'b0, win_len_ff});
   end

   // Classification of the accepted item and next bookkeeping state.
   always_comb begin
      started_in       = started_ff;
      win_len_in       = win_len_ff;
      in_phase_in      = in_phase_ff;
      pending_in       = pending_ff;
      diff_sum_in      = diff_sum_ff;
      last_in          = last_ff;
      head_in          = head_ff;
      push             = 1'b0;
      push_op          = '0;
      push_op.win_len  = win_len_ff;
      if (accept) begin
         if (req_tuser == CMD_DRAIN) begin
            if (pending_ff != '0) begin
               push              = 1'b1;
               push_op.emit      = 1'b1;
               push_op.corrected = (pending_ff > {1'b0, in_phase_ff});
               push_op.has_next  = (pending_ff >= (LEN_W+1)'(2));
               pending_in        = pending_ff - (LEN_W+1)'(1);
               if (pending_ff == (LEN_W+1)'(1)) begin
                  // Final sample of the record: clear the record state.
                  push_op.is_last = 1'b1;
                  started_in      = 1'b0;
                  win_len_in      = LEN_W'(2);
                  in_phase_in     = '0;
                  diff_sum_in     = '0;
                  last_in         = '0;
                  head_in         = '0;
               end
            end
         end else if (!started_ff) begin
            started_in      = 1'b1;
            win_len_in      = len_clamped;
            pending_in      = (LEN_W+1)'(1);
            last_in         = req_tdata;
            push            = 1'b1;
            push_op.wr      = 1'b1;
            push_op.sample  = req_tdata;
            push_op.win_len = len_clamped;
         end else begin
            push              = 1'b1;
            push_op.wr        = 1'b1;
            push_op.sample    = req_tdata;
            push_op.emit      = emit_now;
            push_op.corrected = (pend_new > {1'b0, phase_new});
            push_op.has_next  = (pend_new >= (LEN_W+1)'(2));
            pending_in        = pend_new - (emit_now ? (LEN_W+1)'(1) : '0);
            last_in           = req_tdata;
            diff_sum_in       = diff_new;
            head_in           = head_new;
            in_phase_in       = phase_new;
            if (phase_new >= win_len_ff) begin
               push_op.win_done = 1'b1;
               push_op.diff_sum = diff_new;
               push_op.head     = head_new;
               diff_sum_in      = '0;
               in_phase_in      = '0;
            end
         end
      end
   end

   // Bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= 1'b0;
         win_len_ff  <= LEN_W'(2);
         in_phase_ff <= '0;
         pending_ff  <= '0;
         diff_sum_ff <= '0;
         last_ff     <= '0;
         head_ff     <= '0;
      end else begin
         started_ff  <= started_in;
         win_len_ff  <= win_len_in;
         in_phase_ff <= in_phase_in;
         pending_ff  <= pending_in;
         diff_sum_ff <= diff_sum_in;
         last_ff     <= last_in;
         head_ff     <= head_in;
      end
   end

endmodule

`default_nettype wire

[rtl/wgr_queue.sv]
// ============================================================================
// Window glitch remover operation queue
// A short first-in first-out buffer of classified operations between the
// front and back sections.
// ============================================================================
`default_nettype none

module wgr_queue
   import wgr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire op_type     push_op,
   input  wire logic       pop,
   output op_type          pop_op,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Status and head entry.
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_op       = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

[rtl/wgr_divider.sv]
// ============================================================================
// Window glitch remover threshold divider
// Restoring divider producing one quotient bit per cycle for the window
// threshold.
// ============================================================================
`default_nettype none

module wgr_divider
   import wgr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // One restoring step: shift in the next numerator bit and try to subtract.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      fits    = (rem_sh >= {1'b0, den_ff});
   end

   // Next state of the divider.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

[rtl/wgr_back.sv]
// ============================================================================
// Window glitch remover back section
// Holds the sample store, carries out queued operations: store writes,
// glitch judgement and correction of the oldest sample, and the window
// threshold update.
// ============================================================================
`default_nettype none

module wgr_back
   import wgr_pkg::*;
#(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire queue_status_type   q_status,
   input  wire op_type             pop_op,
   output logic                    pop,
   input  wire logic [ALPHA_W-1:0] cfg_alpha,
   input  wire logic [MODE_W-1:0]  cfg_mode,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int DEPTH = 2 * MAX_WINDOW;
   localparam int AW    = $clog2(DEPTH);

   back_state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] store_mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;

   op_type              op_ff;
   logic [AW-1:0]       wp_ff, rp_ff;
   logic [LEN_W-1:0]    out_phase_ff;
   logic                skip_ff;
   logic [SAMPLE_W-1:0] corr_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                started_ff;
   logic [THR_W-1:0]    thr_ff;
   logic [SAMPLE_W-1:0] cur_ff, prev_ff;

   logic                out_valid_ff;
   logic [SAMPLE_W-1:0] out_sample_ff;
   logic                out_glitch_ff;
   logic                out_last_ff;
   logic [COUNT_W-1:0]  out_total_ff;

   logic                slot_free;
   logic                fire;
   logic                div_start;
   logic                div_done;
   logic [NUM_W-1:0]    div_quo;
   logic [SUM_W-1:0]    total_sum;
   logic [ALPHA_W-1:0]  alpha_eff;
   logic [DEN_W-1:0]    div_den;
   logic [THR_W-1:0]    thr_sat;

   logic [AW-1:0]       rp_next, rp_prev, wp_next;
   logic                phase_zero;
   logic                skip_eff;
   logic [SAMPLE_W-1:0] base;
   logic [SAMPLE_W-1:0] dmag;
   logic                over;
   logic [SAMPLE_W:0]   mean_sum;
   logic [SAMPLE_W-1:0] value_e;
   logic                flag_e;
   logic                skip_e;
   logic [COUNT_W-1:0]  count_e;
   logic [LEN_W-1:0]    phase_e;

   // Circular store addressing.
   always_comb begin
      rp_next = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      rp_prev = (rp_ff == '0) ? AW'(DEPTH - 1) : rp_ff - AW'(1);
      wp_next = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   end

   assign slot_free = !out_valid_ff || rsp_tready;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (op_ff.emit) begin
               state_in = ST_RD_CUR;
            end else if (op_ff.win_done) begin
               state_in = ST_DIV_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_CUR:  state_in = ST_RD_PREV;
         ST_RD_PREV: state_in = ST_RD_NEXT;
         ST_RD_NEXT: state_in = ST_EVAL;
         ST_EVAL: begin
            if (slot_free) begin
               state_in = op_ff.win_done ? ST_DIV_START : ST_IDLE;
            end
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      pop       = (state_ff == ST_IDLE) && !q_status.empty;
      mem_we    = (state_ff == ST_WRITE) && op_ff.wr;
      fire      = (state_ff == ST_EVAL) && slot_free;
      div_start = (state_ff == ST_DIV_START);
      case (state_ff)
         ST_RD_CUR:  rd_addr = rp_ff;
         ST_RD_PREV: rd_addr = rp_prev;
         default:    rd_addr = rp_next;
      endcase
   end

   // Sample store with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wp_ff] <= op_ff.sample;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Glitch judgement and correction of the oldest sample.
   always_comb begin
      phase_zero = (out_phase_ff == '0);
      skip_eff   = phase_zero ? 1'b0 : skip_ff;
      base       = phase_zero ? corr_ff : prev_ff;
      dmag       = abs_diff(cur_ff, base);
      over       = ({{(THR_W-SAMPLE_W){1'b0}}, dmag} > thr_ff);
      mean_sum   = {corr_ff[SAMPLE_W-1], corr_ff} + {rd_data_ff[SAMPLE_W-1], rd_data_ff};
      value_e    = cur_ff;
      flag_e     = 1'b0;
      skip_e     = skip_ff;
      count_e    = count_ff;
      phase_e    = out_phase_ff;
      if (!started_ff) begin
         // The very first sample of a record takes the value of the second, if any.
         if (op_ff.has_next) begin
            value_e = rd_data_ff;
         end
      end else begin
         if (op_ff.corrected) begin
            skip_e = !skip_eff && over;
            if (!skip_eff && over) begin
               flag_e = 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_e = count_ff + COUNT_W'(1);
               end
               case (cfg_mode)
                  MODE_INTERP: value_e = op_ff.has_next ? mean_sum[SAMPLE_W:1] : corr_ff;
                  MODE_ZERO:   value_e = '0;
                  default:     value_e = cur_ff;
               endcase
            end
         end
         phase_e = ((out_phase_ff + LEN_W'(1)) >= op_ff.win_len) ? '0
                                                                : out_phase_ff + LEN_W'(1);
      end
   end

   // Threshold division operands and saturation of its result.
   always_comb begin
      total_sum = op_ff.diff_sum + SUM_W'(abs_diff(op_ff.head, corr_ff));
      alpha_eff = (cfg_alpha == '0) ? ALPHA_W'(1) : cfg_alpha;
      div_den   = DEN_W'(op_ff.win_len) * DEN_W'(alpha_eff);
      thr_sat   = (div_quo[NUM_W-1:THR_W] != '0) ? {THR_W{1'b1}} : div_quo[THR_W-1:0];
   end

   wgr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      ({total_sum, {FRAC_W{1'b0}}}),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Control and record state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         out_phase_ff <= '0;
         skip_ff      <= 1'b0;
         corr_ff      <= '0;
         count_ff     <= '0;
         started_ff   <= 1'b0;
         thr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mem_we) begin
            wp_ff <= wp_next;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            if (op_ff.is_last) begin
               // Record complete: start the next one from a clean state.
               wp_ff        <= '0;
               rp_ff        <= '0;
               out_phase_ff <= '0;
               skip_ff      <= 1'b0;
               corr_ff      <= '0;
               count_ff     <= '0;
               started_ff   <= 1'b0;
               thr_ff       <= '0;
            end else begin
               rp_ff        <= rp_next;
               out_phase_ff <= phase_e;
               skip_ff      <= skip_e;
               corr_ff      <= value_e;
               count_ff     <= count_e;
               started_ff   <= 1'b1;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (div_done) begin
            thr_ff <= thr_sat;
         end
      end
   end

   // Operation, read captures and output payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= pop_op;
      end
      if (state_ff == ST_RD_PREV) begin
         cur_ff <= rd_data_ff;
      end
      if (state_ff == ST_RD_NEXT) begin
         prev_ff <= rd_data_ff;
      end
      if (fire) begin
         out_sample_ff <= value_e;
         out_glitch_ff <= flag_e;
         out_last_ff   <= op_ff.is_last;
         out_total_ff  <= count_e;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W-SAMPLE_W-COUNT_W){1'b0}}, out_total_ff, out_sample_ff};
   assign rsp_tuser  = out_glitch_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

[rtl/window_glitch_remover.sv]
// ============================================================================
// Window glitch remover
// Backward difference one-point deglitch filter over fixed sample windows,
// with corrected samples delivered one window late.
// ============================================================================
//
//  Channel  Direction  Payload
//  req_     in         tdata[31:0] sample_in; tuser cmd (0 sample, 1 drain)
//  rsp_     out        tdata[31:0] sample_out, [51:32] glitch_total;
//                      tuser glitch; tlast last
//  csr_     in         index 0 window_len, 1 alpha, 2 mode; data[15:0]
//
// A sample that releases a result passes through the back section's queue
// pop, store write, three store reads and one evaluation; a sample that
// releases none passes only the pop and the write. Each completed window
// adds a run of the bit-serial threshold divider. The front takes one
// transfer per cycle while the two-entry queue has room. Reset is
// synchronous; the store needs no clearing pass. A stalled result channel
// holds the back section only when a further result is ready.
//
`default_nettype none

module window_glitch_remover
   import wgr_pkg::*;
#(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [SAMPLE_W-1:0] req_tdata,   // sample_in
   input  wire logic                req_tuser,   // cmd
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata,   // sample_out, glitch_total
   output logic                     rsp_tuser,   // glitch
   output logic                     rsp_tlast,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [IDX_W-1:0]    csr_index,
   input  wire logic [CSR_W-1:0]    csr_data
);

   logic [LEN_W-1:0]   window_len_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [MODE_W-1:0]  mode_ff;

   queue_status_type   q_status;
   logic               push;
   logic               pop;
   op_type             push_op;
   op_type             pop_op;

   // Configuration registers; every transfer is taken at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         alpha_ff      <= ALPHA_RESET;
         mode_ff       <= MODE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_LEN: window_len_ff <= csr_data[LEN_W-1:0];
            REG_ALPHA:      alpha_ff      <= csr_data[ALPHA_W-1:0];
            REG_MODE:       mode_ff       <= csr_data[MODE_W-1:0];
            default:        ;
         endcase
      end
   end

   wgr_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .cfg_window_len (window_len_ff),
      .q_status       (q_status),
      .push           (push),
      .push_op        (push_op)
   );

   wgr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .pop_op  (pop_op),
      .status  (q_status)
   );

   wgr_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_op     (pop_op),
      .pop        (pop),
      .cfg_alpha  (alpha_ff),
      .cfg_mode   (mode_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ============================================================================
// Window glitch remover testbench
// Drives sample and drain transfers through several register settings and
// checks every result against a cycle-free prediction of the filter.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
   import wgr_pkg::*;

   localparam int STORE_DEPTH = 2 * DEFAULT_MAX_WINDOW;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam logic [SAMPLE_W-1:0] SIGN_BIT = 32'h8000_0000;

   // One expected result transfer.
   typedef struct {
      logic [SAMPLE_W-1:0] value;
      logic                flag;
      logic                last;
      logic [COUNT_W-1:0]  total;
   } filtered_sample_type;

   // Scoreboard: predicts the filter output and checks result transfers.
   class glitch_scoreboard;
      logic [SAMPLE_W-1:0] store [STORE_DEPTH];
      longint unsigned     diff_acc, threshold;
      int unsigned         wr_pos, rd_pos, in_pos, out_pos, buffered, win_len;
      bit                  skip_following, started, out_begun;
      logic [SAMPLE_W-1:0] prev_corrected, window_head, prev_input;
      logic [COUNT_W-1:0]  glitch_count;
      logic [LEN_W-1:0]    reg_len;
      logic [ALPHA_W-1:0]  reg_alpha;
      logic [MODE_W-1:0]   reg_mode;
      filtered_sample_type expected_q [$];
      int                  failures;

      function new();
         reg_len = WINDOW_LEN_RESET;
         reg_alpha = ALPHA_RESET;
         reg_mode = MODE_RESET;
         failures = 0;
         clear_record();
      endfunction

      function void clear_record();
         diff_acc = 0; threshold = 0; wr_pos = 0; rd_pos = 0;
         skip_following = 0; prev_corrected = '0; glitch_count = '0;
         started = 0; win_len = 2; in_pos = 0; out_pos = 0; buffered = 0;
         out_begun = 0; window_head = '0; prev_input = '0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx == REG_WINDOW_LEN) reg_len = data[LEN_W-1:0];
         else if (idx == REG_ALPHA) reg_alpha = data[ALPHA_W-1:0];
         else if (idx == REG_MODE) reg_mode = data[MODE_W-1:0];
      endfunction

      function longint unsigned magnitude(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
         longint d;
         d = longint'(signed'(a)) - longint'(signed'(b));
         return (d < 0) ? longint'(-d) : d;
      endfunction

      function logic [SAMPLE_W-1:0] floor_mean(logic [SAMPLE_W-1:0] a,
                                               logic [SAMPLE_W-1:0] b);
         logic [SAMPLE_W:0] s;
         s = {1'b0, a ^ SIGN_BIT} + {1'b0, b ^ SIGN_BIT};
         return s[SAMPLE_W:1] ^ SIGN_BIT;
      endfunction

      function int unsigned wrap_next(int unsigned i);
         return (i + 1 >= STORE_DEPTH) ? 0 : i + 1;
      endfunction

      // Release the oldest buffered sample, corrected when its window is whole.
      function void release_oldest(bit corrected, bit is_last);
         filtered_sample_type r;
         longint unsigned     d;
         r.value = store[rd_pos];
         r.flag = 0;
         if (!out_begun) begin
            out_begun = 1;
            if (buffered >= 2) r.value = store[wrap_next(rd_pos)];
         end else begin
            if (corrected) begin
               if (out_pos == 0) begin
                  skip_following = 0;
                  d = magnitude(r.value, prev_corrected);
               end else begin
                  d = magnitude(r.value, store[(rd_pos == 0) ? STORE_DEPTH - 1 : rd_pos - 1]);
               end
               if (skip_following) begin
                  skip_following = 0;
               end else if (d > threshold) begin
                  r.flag = 1;
                  skip_following = 1;
                  if (glitch_count != COUNT_MAX) glitch_count++;
                  if (reg_mode == MODE_INTERP) begin
                     r.value = (buffered >= 2) ?
                        floor_mean(prev_corrected, store[wrap_next(rd_pos)]) : prev_corrected;
                  end else if (reg_mode == MODE_ZERO) begin
                     r.value = '0;
                  end
               end
            end
            out_pos++;
            if (out_pos >= win_len) out_pos = 0;
         end
         prev_corrected = r.value;
         rd_pos = wrap_next(rd_pos);
         buffered--;
         r.total = glitch_count;
         r.last = is_last && (buffered == 0);
         expected_q.push_back(r);
      endfunction

      // Account for one accepted request transfer.
      function void note_item(logic cmd, logic [SAMPLE_W-1:0] s);
         longint unsigned a;
         if (cmd == CMD_DRAIN) begin
            if (buffered == 0) return;
            release_oldest(buffered > in_pos, 1);
            if (buffered == 0) clear_record();
            return;
         end
         if (!started) begin
            win_len = (reg_len < 2) ? 2 :
                      (reg_len > DEFAULT_MAX_WINDOW) ? DEFAULT_MAX_WINDOW : reg_len;
            started = 1;
            store[wr_pos] = s;
            wr_pos = wrap_next(wr_pos);
            buffered++;
            prev_input = s;
            return;
         end
         store[wr_pos] = s;
         wr_pos = wrap_next(wr_pos);
         if (in_pos == 0) window_head = s;
         else diff_acc += magnitude(s, prev_input);
         prev_input = s;
         in_pos++;
         buffered++;
         if (buffered > win_len) release_oldest(buffered > in_pos, 0);
         if (in_pos >= win_len) begin
            a = (reg_alpha == 0) ? 1 : reg_alpha;
            diff_acc += magnitude(window_head, prev_corrected);
            threshold = (diff_acc << FRAC_W) / (longint'(win_len) * a);
            if (threshold > (64'd1 << THR_W) - 1) threshold = (64'd1 << THR_W) - 1;
            diff_acc = 0;
            in_pos = 0;
         end
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_result(logic [RSP_W-1:0] data, logic user, logic last);
         filtered_sample_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result transfer sample_out %0d", signed'(data[31:0]));
            failures++;
            return;
         end
         e = expected_q.pop_front();
         if (data[31:0] !== e.value) begin
            $error("sample_out expected %0d actual %0d", signed'(e.value), signed'(data[31:0]));
            failures++;
         end
         if (user !== e.flag) begin
            $error("glitch expected %0d actual %0d", e.flag, user);
            failures++;
         end
         if (last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, last);
            failures++;
         end
         if (data[51:32] !== e.total) begin
            $error("glitch_total expected %0d actual %0d", e.total, data[51:32]);
            failures++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata = '0;   // sample_in
   logic                req_tuser = 0;    // cmd
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RSP_W-1:0]    rsp_tdata;        // sample_out, glitch_total
   logic                rsp_tuser;        // glitch
   logic                rsp_tlast;
   logic                csr_valid = 0;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]    csr_data = '0;

   glitch_scoreboard    sb = new();
   int unsigned         cycle_count = 0;
   int unsigned         burst_left = 0;
   int unsigned         stall_kind = 0;
   logic [7:0]          stall_pattern = 8'hA5;
   logic [SAMPLE_W-1:0] walk_value = '0;
   int unsigned         items_sent = 0;

   window_glitch_remover dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Cycle limit and result monitor.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Receiver stalls follow a randomly drawn kind and pattern; the pattern rotates between draws.
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) begin
         stall_kind <= $urandom_range(0, 3);
         stall_pattern <= 8'($urandom);
      end else begin
         stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
      end
      case (stall_kind)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= stall_pattern[0];
         default: rsp_tready <= 1'($urandom_range(0, 1));
      endcase
   end

   // One request transfer, with bursts and random gaps; valid stays high.
   task automatic send_item(logic cmd, logic [SAMPLE_W-1:0] s);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tuser <= cmd;
      req_tdata <= s;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_item(cmd, s);
      items_sent++;
   endtask

   // Hold the sender until every expected result has arrived and the block settles.
   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic configure(logic [CSR_W-1:0] len, logic [CSR_W-1:0] alpha,
                            logic [CSR_W-1:0] mode);
      csr_write(REG_WINDOW_LEN, len);
      csr_write(REG_ALPHA, alpha);
      csr_write(REG_MODE, mode);
   endtask

   // Slow random walk with occasional spikes, extremes and raw words.
   function automatic logic [SAMPLE_W-1:0] next_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      walk_value = walk_value + $urandom_range(0, 200) - 100;
      if (pick < 12) return walk_value + ($urandom_range(0, 1) ? 32'd5000000 : -32'd5000000);
      if (pick < 15) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (pick < 20) return $urandom;
      return walk_value;
   endfunction

   // Flush the record, with a few drains that find nothing buffered.
   task automatic drain_all();
      while (sb.buffered != 0) send_item(CMD_DRAIN, $urandom);
      repeat ($urandom_range(0, 2)) send_item(CMD_DRAIN, $urandom);
   endtask

   // A record of n samples, sometimes with a partial drain in the middle.
   task automatic run_record(int unsigned n);
      int unsigned split;
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
      for (int unsigned i = 0; i < split; i++) send_item(CMD_SAMPLE, next_sample());
      if (split < n) begin
         repeat ($urandom_range(1, 4)) if (sb.buffered > 1) send_item(CMD_DRAIN, 0);
         for (int unsigned i = split; i < n; i++) send_item(CMD_SAMPLE, next_sample());
      end
      drain_all();
   endtask

   initial begin
      logic [CSR_W-1:0] len, alpha;
      int unsigned      records, limit_len;
      repeat (10) @(posedge clock);
      reset <= 0;
      repeat (5) @(posedge clock);

      // Directed: single-sample record at reset settings, then extremes.
      send_item(CMD_SAMPLE, 32'h7FFF_FFFF);
      send_item(CMD_DRAIN, 0);
      send_item(CMD_DRAIN, 0);
      wait_idle();
      configure(2, 0, CSR_W'(MODE_INTERP));
      send_item(CMD_SAMPLE, 32'h8000_0000);
      send_item(CMD_SAMPLE, 32'h8000_0000);
      send_item(CMD_SAMPLE, 32'h7FFF_FFFF);
      send_item(CMD_SAMPLE, 32'h8000_0000);
      send_item(CMD_SAMPLE, 0);
      send_item(CMD_SAMPLE, 32'h7FFF_FFFF);
      send_item(CMD_SAMPLE, 5);
      drain_all();
      wait_idle();
      configure(3, 16'hFFFF, CSR_W'(MODE_ZERO));
      for (int i = 0; i < 8; i++) send_item(CMD_SAMPLE, (i == 4) ? 32'd90000 : i);
      drain_all();
      wait_idle();
      configure(16'h07FF, 1, 3);
      for (int i = 0; i < 6; i++) send_item(CMD_SAMPLE, $urandom);
      drain_all();
      wait_idle();

      // Random phases through many settings.
      while (items_sent < 900) begin
         case ($urandom_range(0, 9))
            0: len = CSR_W'($urandom_range(0, 1));
            1: len = ($urandom_range(0, 5) == 0) ? 16'd1024 : 16'd2;
            2: len = CSR_W'($urandom_range(2, 40));
            default: len = CSR_W'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 5))
            0: alpha = '0;
            1: alpha = 16'hFFFF;
            2: alpha = CSR_W'($urandom);
            3: alpha = 16'd410;
            default: alpha = CSR_W'($urandom_range(1024, 8192));
         endcase
         configure(len, alpha, CSR_W'($urandom_range(0, 3)));
         limit_len = (sb.reg_len < 2) ? 2 : (sb.reg_len > 64) ? 20 : sb.reg_len;
         records = $urandom_range(1, 3);
         repeat (records) run_record($urandom_range(1, 3 * limit_len + 5));
         wait_idle();
      end

      wait_idle();
      if (sb.failures == 0 && sb.expected_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

[window_glitch_remover.f]
rtl/wgr_pkg.sv
rtl/wgr_front.sv
rtl/wgr_queue.sv
rtl/wgr_divider.sv
rtl/wgr_back.sv
rtl/window_glitch_remover.sv
tb/tb_top.sv
